[hw/rtl/palette_nearest_color_core_assert.svh]
// ----------------------------------------------------------------------------
// Palette nearest color core assertion macros
// Concurrent assertion helpers shared by the palette search RTL.
// ----------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOR_CORE_ASSERT_SVH
`define PALETTE_NEAREST_COLOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold in every cycle outside reset.
`define PNC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PNC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PNC_ASSERT(name, clk, rst_n, prop, msg)
`define PNC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/pnc_pkg.sv]
// ----------------------------------------------------------------------------
// Palette nearest color package
// Shared constants and types for the palette nearest color search.
// ----------------------------------------------------------------------------
package pnc_pkg;

    // Default palette depth.
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Size of the index space addressed by an 8-bit palette index.
    localparam int INDEX_SPACE = 256;

    // Above the largest channel value; the empty-range distance 3 * 257^2 exceeds any real one.
    localparam int CHANNEL_SPAN = 257;

    localparam int COLOR_W    = 8;
    localparam int INDEX_W    = 8;
    localparam int SCAN_W     = 9;
    localparam int SQUARE_W   = 16;
    localparam int DISTANCE_W = 18;
    localparam int ENTRY_W    = 3 * COLOR_W;

    localparam logic [DISTANCE_W-1:0] NO_MATCH_DISTANCE =
        DISTANCE_W'(3 * CHANNEL_SPAN * CHANNEL_SPAN);

    // Input transaction kinds carried on tuser.
    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_FIRST = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_END   = 1'b1;

    localparam logic [SCAN_W-1:0] SEARCH_END_RESET = 9'd256;

endpackage

[hw/rtl/palette_nearest_color_core.sv]
// ----------------------------------------------------------------------------
// Palette nearest color core
// Palette memory with a sequential nearest-color search by squared RGB
// distance.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions arrive on the s_axis channel. tuser carries the opcode:
// a write transaction stores {red, green, blue} at entry_index when that
// index is below the palette depth and produces no output; a query
// transaction carries an RGB color and produces exactly one output
// transaction on m_axis with the nearest palette index, its squared distance
// and an exact-match flag. A query scans the palette from search_first up to
// (but excluding) the smallest of search_end, the palette depth and the index
// space of 256, one entry per cycle through the single port of the palette
// memory; the scan ends early at the first exact match. An empty range
// returns search_first with the sentinel distance 198147. While a query
// scans, s_axis_tready is low. A finished result is held in an output
// register, so a new query may start while the previous result waits; if
// the receiver stalls, a second result waits in the search core until the
// output register frees up.
// Reset clears the control state and sets search_first to 0 and search_end
// to 256. Palette contents are undefined until written.
// ----------------------------------------------------------------------------
module palette_nearest_color_core
    import pnc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [31:0]            s_axis_tdata,
    // tuser: opcode[0]
    input  logic [0:0]             s_axis_tuser,

    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: best_index[7:0], best_distance[25:8], exact_match[26], zero[31:27]
    output logic [31:0]            m_axis_tdata
);

    `include "palette_nearest_color_core_assert.svh"

    localparam int ADDR_W   = $clog2(PALETTE_ENTRIES);
    // Highest exclusive scan bound: the palette depth, capped by the index space.
    localparam int SCAN_CAP = (PALETTE_ENTRIES < INDEX_SPACE) ? PALETTE_ENTRIES : INDEX_SPACE;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0] in_entry_index;
    logic [COLOR_W-1:0] in_red;
    logic [COLOR_W-1:0] in_green;
    logic [COLOR_W-1:0] in_blue;
    opcode_t            in_opcode;

    assign in_entry_index = s_axis_tdata[7:0];
    assign in_red         = s_axis_tdata[15:8];
    assign in_green       = s_axis_tdata[23:16];
    assign in_blue        = s_axis_tdata[31:24];
    assign in_opcode      = opcode_t'(s_axis_tuser[0]);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0] search_first_reg;
    logic [SCAN_W-1:0]  search_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_first_reg <= '0;
            search_end_reg   <= SEARCH_END_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEARCH_FIRST: search_first_reg <= cfg_data[INDEX_W-1:0];
                REG_SEARCH_END:   search_end_reg   <= cfg_data[SCAN_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and pipeline registers
    // ------------------------------------------------------------------
    state_t              state_reg;
    logic [SCAN_W-1:0]   scan_cnt_reg;
    logic [SCAN_W-1:0]   limit_reg;
    logic [COLOR_W-1:0]  q_red_reg;
    logic [COLOR_W-1:0]  q_green_reg;
    logic [COLOR_W-1:0]  q_blue_reg;
    logic                rd_valid_reg;
    logic [INDEX_W-1:0]  rd_idx_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                sq_valid_reg;
    logic [INDEX_W-1:0]  sq_idx_reg;
    logic [SQUARE_W-1:0] sq_red_reg;
    logic [SQUARE_W-1:0] sq_green_reg;
    logic [SQUARE_W-1:0] sq_blue_reg;
    logic [INDEX_W-1:0]    best_idx_reg;
    logic [DISTANCE_W-1:0] best_dist_reg;
    logic                  hit_reg;
    logic                  m_valid_reg;
    logic [INDEX_W-1:0]    m_index_reg;
    logic [DISTANCE_W-1:0] m_dist_reg;
    logic                  m_exact_reg;

    logic                  in_fire;
    logic                  wr_fire;
    logic                  query_fire;
    logic                  wr_in_range;
    logic                  issue;
    logic                  scan_done;
    logic                  out_free;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [SCAN_W-1:0]     limit_next;
    logic [COLOR_W-1:0]    diff_red;
    logic [COLOR_W-1:0]    diff_green;
    logic [COLOR_W-1:0]    diff_blue;
    logic [DISTANCE_W-1:0] dist_sum;
    logic                  dist_better;

    // Inputs are taken only between queries: this is the interlock that keeps
    // palette writes off the port while a scan is reading it.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign wr_in_range   = (32'(in_entry_index) < 32'(PALETTE_ENTRIES));
    assign wr_fire       = in_fire && (in_opcode == OP_WRITE) && wr_in_range;
    assign query_fire    = in_fire && (in_opcode == OP_QUERY);

    assign limit_next = (search_end_reg > SCAN_W'(SCAN_CAP)) ? SCAN_W'(SCAN_CAP)
                                                             : search_end_reg;

    // One palette read per cycle until the range is exhausted or an exact
    // match has been seen. Reads already in flight after a hit cannot beat a
    // zero distance, so they drain without effect.
    assign issue     = (state_reg == ST_SCAN) && (scan_cnt_reg < limit_reg) && !hit_reg;
    assign scan_done = (state_reg == ST_SCAN) && !issue && !rd_valid_reg && !sq_valid_reg;
    assign out_free  = !m_valid_reg || m_axis_tready;

    assign wr_addr = ADDR_W'(in_entry_index);
    assign rd_addr = ADDR_W'(scan_cnt_reg);

    // ------------------------------------------------------------------
    // Palette memory: single port, registered read data.
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] palette_mem [PALETTE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            palette_mem[wr_addr] <= {in_red, in_green, in_blue};
        end
        else if (issue)
        begin
            rd_data_reg <= palette_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Distance datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        diff_red   = (q_red_reg > rd_data_reg[23:16]) ? (q_red_reg - rd_data_reg[23:16])
                                                      : (rd_data_reg[23:16] - q_red_reg);
        diff_green = (q_green_reg > rd_data_reg[15:8]) ? (q_green_reg - rd_data_reg[15:8])
                                                       : (rd_data_reg[15:8] - q_green_reg);
        diff_blue  = (q_blue_reg > rd_data_reg[7:0]) ? (q_blue_reg - rd_data_reg[7:0])
                                                     : (rd_data_reg[7:0] - q_blue_reg);
        dist_sum   = DISTANCE_W'(sq_red_reg) + DISTANCE_W'(sq_green_reg)
                   + DISTANCE_W'(sq_blue_reg);
        // Strict compare keeps the lowest index on a tie.
        dist_better = sq_valid_reg && (dist_sum < best_dist_reg);
    end

    // Squares of the channel differences, query color and read index; payload, no reset.
    always_ff @(posedge clk)
    begin
        sq_idx_reg   <= rd_idx_reg;
        sq_red_reg   <= SQUARE_W'(diff_red) * SQUARE_W'(diff_red);
        sq_green_reg <= SQUARE_W'(diff_green) * SQUARE_W'(diff_green);
        sq_blue_reg  <= SQUARE_W'(diff_blue) * SQUARE_W'(diff_blue);
        if (query_fire)
        begin
            q_red_reg   <= in_red;
            q_green_reg <= in_green;
            q_blue_reg  <= in_blue;
        end
        if (issue)
        begin
            rd_idx_reg <= scan_cnt_reg[INDEX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, running minimum and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            limit_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= NO_MATCH_DISTANCE;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_index_reg   <= '0;
            m_dist_reg    <= '0;
            m_exact_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            sq_valid_reg <= rd_valid_reg;

            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (query_fire)
                    begin
                        scan_cnt_reg  <= {1'b0, search_first_reg};
                        limit_reg     <= limit_next;
                        best_idx_reg  <= search_first_reg;
                        best_dist_reg <= NO_MATCH_DISTANCE;
                        hit_reg       <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (issue)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    if (dist_better)
                    begin
                        best_dist_reg <= dist_sum;
                        best_idx_reg  <= sq_idx_reg;
                        if (dist_sum == '0)
                        begin
                            hit_reg <= 1'b1;
                        end
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_index_reg <= best_idx_reg;
                        m_dist_reg  <= best_dist_reg;
                        m_exact_reg <= (best_dist_reg == '0);
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_exact_reg, m_dist_reg, m_index_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PNC_ASSERT(a_idle_pipe_empty, clk, rst_n,
        !s_axis_tready || (!rd_valid_reg && !sq_valid_reg),
        "palette read pipeline busy while inputs are accepted")
    `PNC_ASSERT(a_hit_zero, clk, rst_n, !hit_reg || (best_dist_reg == '0),
        "exact match flagged with a nonzero best distance")
    `PNC_ASSERT(a_dist_bound, clk, rst_n, best_dist_reg <= NO_MATCH_DISTANCE,
        "best distance above the empty-range sentinel")
    `PNC_ASSERT_NEXT(a_read_to_square, clk, rst_n, rd_valid_reg, sq_valid_reg,
        "palette read did not reach the distance stage")

endmodule
